// ===== rtl/fca_pkg.sv =====
// Shared types and constants for the flow cache accounting block.
package fca_pkg;
  localparam int TABLE_ENTRIES = 256;
  localparam int PROBE_WINDOW  = 8;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [5:0]  FLAG_BITS  = 6'h3F;

  localparam logic [2:0] KIND_IGNORED = 3'd0;
  localparam logic [2:0] KIND_HIT     = 3'd1;
  localparam logic [2:0] KIND_NEW     = 3'd2;
  localparam logic [2:0] KIND_EVICT   = 3'd3;
  localparam logic [2:0] KIND_KEEP    = 3'd4;
  localparam logic [2:0] KIND_EXPORT  = 3'd5;

  localparam logic [1:0] REG_DIR_MASK = 2'd0;
  localparam logic [1:0] REG_IDLE     = 2'd1;
  localparam logic [1:0] REG_ACTIVE   = 2'd2;

  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_SWEEP  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [1:0]  direction;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  raw_tcp_flags;
    logic [15:0] frame_len;
    logic [31:0] now_ms;
    logic [7:0]  slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  entry;
    logic [31:0] flow_src_ip;
    logic [31:0] flow_dst_ip;
    logic [15:0] flow_sport;
    logic [15:0] flow_dport;
    logic [7:0]  flow_proto;
    logic [5:0]  flow_flags;
    logic [31:0] pkt_count;
    logic [31:0] byte_count;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
  } rsp_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [31:0] packets;
    logic [31:0] octets;
    logic [31:0] start;
    logic [31:0] recent;
    logic [5:0]  flags;
  } flow_t;
endpackage

// ===== rtl/fca_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface fca_req_if;
  import fca_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fca_rsp_if;
  import fca_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fca_hash.sv =====
// Byte-serial FNV-1a hash unit over the 13-byte flow key.
module fca_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [103:0] key,
  output logic        done,
  output logic [31:0] hash
);
  import fca_pkg::*;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] h_r, h_nxt;
  logic [7:0]  b;
  logic [31:0] prod;

  assign b = key[cnt_r*8 +: 8];
  assign prod = (h_r ^ {24'd0, b}) * HASH_PRIME;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    h_nxt = h_r;
    if (start) begin
      cnt_nxt = 4'd0;
      busy_nxt = 1'b1;
      h_nxt = HASH_BASIS;
    end else if (busy_r) begin
      h_nxt = prod;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd12) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    h_r <= h_nxt;
  end

  assign done = !busy_r && !start;
  assign hash = h_r;
endmodule

// ===== rtl/flow_cache_accounting.sv =====
// Flow cache accounting top level: control sequencer and flow memory.
// Packet request: hash start, hash, probe passes for a hit, a free slot and, on
// eviction, the oldest entry, then update; sweep: read and check one slot; an
// ignored request is answered from idle. Next request taken once the result is accepted.
// Synchronous active-low reset clears valid bits and config to reset values;
// flow memory contents are undefined until written.
module flow_cache_accounting (
  input  logic        clk,
  input  logic        rst_n,
  fca_req_if.sink     in_req,
  fca_rsp_if.source   out_rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import fca_pkg::*;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(PROBE_WINDOW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HASH  = 4'd1;
  localparam logic [3:0] S_HIT   = 4'd2;
  localparam logic [3:0] S_FREE  = 4'd3;
  localparam logic [3:0] S_OLD   = 4'd4;
  localparam logic [3:0] S_RDPK  = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_SWRD  = 4'd7;
  localparam logic [3:0] S_SWCK  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_HSTART = 4'd10;

  logic [1:0]  dmask_r;
  logic [31:0] idle_r, active_r;
  logic [3:0]  st_r;
  req_t        req_r;
  logic [AW-1:0] bucket_r, pick_r;
  logic [PW-1:0] idx_r;
  logic        pvalid_r;
  logic [31:0] oldt_r;
  logic [2:0]  kind_r;
  logic [TABLE_ENTRIES-1:0] vbits_r;
  flow_t       mem [TABLE_ENTRIES];
  flow_t       rd_r;
  logic [AW-1:0] rd_addr;
  logic        rd_en;
  logic [AW-1:0] raddr_r;
  logic        we;
  flow_t       wdata;
  logic        hstart, hdone;
  logic [31:0] hash;
  rsp_t        rsp_r;
  logic        ovalid_r;
  logic [31:0] ports;
  logic        keymatch, vld_rd;
  flow_t       upd;

  assign ports = {req_r.dport, req_r.sport};
  assign vld_rd = vbits_r[raddr_r];
  assign keymatch = rd_r.src == req_r.src_ip && rd_r.dst == req_r.dst_ip &&
                    rd_r.ports == ports && rd_r.proto == req_r.proto;

  fca_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hstart),
    .key({req_r.proto, req_r.dport, req_r.sport, req_r.dst_ip, req_r.src_ip}),
    .done(hdone), .hash(hash)
  );

  assign in_req.ready = (st_r == S_IDLE) && !ovalid_r;
  assign out_rsp.valid = ovalid_r;
  assign out_rsp.data = rsp_r;
  assign hstart = (st_r == S_HSTART);

  // probe address: bucket plus index, wrapping
  logic [AW:0] sum;
  assign sum = {1'b0, bucket_r} + {{(AW + 1 - PW){1'b0}}, idx_r};
  always_comb begin
    rd_addr = sum[AW-1:0];
    if ({1'b0, sum} >= (AW + 2)'(TABLE_ENTRIES)) rd_addr = AW'({1'b0, sum} - (AW + 2)'(TABLE_ENTRIES));
    rd_en = (st_r == S_HIT) || (st_r == S_FREE) || (st_r == S_OLD);
    if (st_r == S_RDPK) begin
      rd_addr = pick_r;
      rd_en = 1'b1;
    end
    if (st_r == S_SWRD) begin
      rd_addr = req_r.slot[AW-1:0];
      rd_en = 1'b1;
    end
  end

  always_comb begin
    upd = rd_r;
    if (kind_r != KIND_HIT) begin
      upd.src = req_r.src_ip;
      upd.dst = req_r.dst_ip;
      upd.ports = ports;
      upd.proto = req_r.proto;
      upd.packets = 32'd0;
      upd.octets = 32'd0;
      upd.start = req_r.now_ms;
      upd.flags = 6'd0;
    end
    upd.packets = upd.packets + 32'd1;
    upd.octets = upd.octets + {16'd0, req_r.frame_len};
    upd.recent = req_r.now_ms;
    upd.flags = (upd.flags | req_r.raw_tcp_flags[5:0]) & FLAG_BITS;
  end
  assign we = (st_r == S_UPD);
  assign wdata = upd;

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
    if (we) mem[pick_r] <= wdata;
  end

  function automatic rsp_t mk(input logic [2:0] k, input logic [7:0] e, input flow_t f);
    rsp_t r;
    r.kind = k;
    r.entry = e;
    r.flow_src_ip = f.src;
    r.flow_dst_ip = f.dst;
    r.flow_sport = f.ports[15:0];
    r.flow_dport = f.ports[31:16];
    r.flow_proto = f.proto;
    r.flow_flags = f.flags;
    r.pkt_count = f.packets;
    r.byte_count = f.octets;
    r.first_seen = f.start;
    r.last_seen = f.recent;
    return r;
  endfunction

  logic [31:0] age_l, age_f;
  logic [31:0] tdiff;
  assign age_l = req_r.now_ms - rd_r.recent;
  assign age_f = req_r.now_ms - rd_r.start;
  assign tdiff = rd_r.recent - oldt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
      vbits_r <= '0;
      dmask_r <= 2'd0;
      idle_r <= 32'd60000;
      active_r <= 32'd300000;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_MASK: dmask_r <= cfg_wdata[1:0];
          REG_IDLE:     idle_r <= cfg_wdata;
          REG_ACTIVE:   active_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_rsp.valid && out_rsp.ready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            req_r <= in_req.data;
            if (in_req.data.func == FUNC_SWEEP) begin
              if (dmask_r == 2'd0) begin
                rsp_r <= mk(KIND_IGNORED, 8'd0, '0);
                ovalid_r <= 1'b1;
              end else if ({24'd0, in_req.data.slot} >= 32'(TABLE_ENTRIES)) begin
                rsp_r <= mk(KIND_IGNORED, in_req.data.slot, '0);
                ovalid_r <= 1'b1;
              end else begin
                st_r <= S_SWRD;
              end
            end else if ((in_req.data.direction & dmask_r) == 2'd0) begin
              rsp_r <= mk(KIND_IGNORED, 8'd0, '0);
              ovalid_r <= 1'b1;
            end else begin
              st_r <= S_HSTART;
            end
          end
        end
        S_HSTART: st_r <= S_HASH;
        S_HASH: begin
          if (hdone) begin
            bucket_r <= hash[AW-1:0] - AW'(0);
            idx_r <= '0;
            pvalid_r <= 1'b0;
            st_r <= S_HIT;
          end
        end
        S_HIT, S_FREE, S_OLD: begin
          // address issued this cycle; evaluate previous read
          raddr_r <= rd_addr;
          if (idx_r == PW'(PROBE_WINDOW)) begin
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + PW'(1);
          end
          if (idx_r != '0) begin
            if (st_r == S_HIT && vld_rd && keymatch && !pvalid_r) begin
              pvalid_r <= 1'b1;
              pick_r <= raddr_r;
            end
            if (st_r == S_FREE && !vld_rd && !pvalid_r) begin
              pvalid_r <= 1'b1;
              pick_r <= raddr_r;
            end
            if (st_r == S_OLD) begin
              if (idx_r == PW'(1)) begin
                pick_r <= raddr_r;
                oldt_r <= rd_r.recent;
              end else if (vld_rd && tdiff[31]) begin
                pick_r <= raddr_r;
                oldt_r <= rd_r.recent;
              end
            end
          end
          if (idx_r == PW'(PROBE_WINDOW)) begin
            case (st_r)
              S_HIT: begin
                if (pvalid_r || (vld_rd && keymatch)) begin
                  kind_r <= KIND_HIT;
                  st_r <= S_RDPK;
                end else begin
                  st_r <= S_FREE;
                end
              end
              S_FREE: begin
                if (pvalid_r || !vld_rd) begin
                  kind_r <= KIND_NEW;
                  st_r <= S_RDPK;
                end else begin
                  st_r <= S_OLD;
                end
              end
              default: begin
                kind_r <= KIND_EVICT;
                st_r <= S_RDPK;
              end
            endcase
          end
        end
        S_RDPK: st_r <= S_UPD;
        S_UPD: begin
          vbits_r[pick_r] <= 1'b1;
          rsp_r <= mk(kind_r, 8'(pick_r), upd);
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_SWRD: st_r <= S_SWCK;
        S_SWCK: begin
          if (!vbits_r[req_r.slot[AW-1:0]]) begin
            rsp_r <= mk(KIND_KEEP, req_r.slot, '0);
          end else if (age_l >= idle_r || age_f >= active_r) begin
            rsp_r <= mk(KIND_EXPORT, req_r.slot, rd_r);
            vbits_r[req_r.slot[AW-1:0]] <= 1'b0;
          end else begin
            rsp_r <= mk(KIND_KEEP, req_r.slot, rd_r);
          end
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_req.ready) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    we |=> vbits_r[$past(pick_r)]) else $error("written slot not valid");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_rsp.ready) |=> ovalid_r) else $error("result dropped");
endmodule
